>>> hw/rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, constants and the nibble decoder for the hex record word
// extractor.
// ----------------------------------------------------------------------------
package ihex_pkg;

    // ring entry kinds
    localparam logic [1:0] KIND_LENGTH  = 2'd0;
    localparam logic [1:0] KIND_ADDRESS = 2'd1;
    localparam logic [1:0] KIND_DATA    = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam int         POS_W        = 10;
    localparam logic [9:0] POS_MAX      = 10'd1023;
    localparam logic [9:0] HEADER_CHARS = 10'd9;

    localparam int TDATA_W = 40;
    localparam int TUSER_W = 2;

    typedef struct packed {
        logic        write_enable;
        logic [1:0]  write_kind;
        logic [5:0]  write_slot;
        logic [15:0] write_value;
        logic [15:0] word_count;
    } ihex_result_t;

    // uppercase hex digits only, anything else reads as zero
    function automatic logic [3:0] decode_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

>>> hw/rtl/ihex_core.sv
// ----------------------------------------------------------------------------
// ihex_core
// Record state registers and the single-pass step logic: one character in,
// one ring entry result out.
// ----------------------------------------------------------------------------
module ihex_core #(
    parameter int RING_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            in_char,
    output ihex_pkg::ihex_result_t result
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [9:0]       char_position_reg, char_position_next;
    logic [9:0]       line_length_reg, line_length_next;
    logic [15:0]      low_acc_reg, low_acc_next;
    logic [15:0]      high_acc_reg, high_acc_next;
    logic [PTR_W-1:0] ring_ptr_reg, ring_ptr_next;
    logic [15:0]      data_words_reg, data_words_next;

    logic [9:0]  pos;
    logic [3:0]  nib;
    logic [15:0] nib16;
    logic [15:0] low_sum;
    logic [15:0] high_new;
    logic        take;
    logic [1:0]  kind;
    logic [15:0] value;
    logic [31:0] slot_wide;

    always_comb begin
        nib   = ihex_pkg::decode_nibble(in_char);
        nib16 = {12'd0, nib};
        pos   = (in_char == ihex_pkg::CHAR_COLON) ? 10'd0 : char_position_reg;

        line_length_next = line_length_reg;
        low_acc_next     = low_acc_reg;
        high_acc_next    = high_acc_reg;
        data_words_next  = data_words_reg;
        take             = 1'b0;
        kind             = ihex_pkg::KIND_LENGTH;
        value            = 16'd0;
        low_sum          = low_acc_reg + nib16;
        high_new         = {high_acc_reg[7:0] + {4'd0, nib}, 8'd0};

        // header fields
        case (pos)
            10'd1, 10'd3: begin
                low_acc_next = {8'd0, nib, 4'd0};
            end
            10'd2: begin
                low_acc_next     = low_sum;
                line_length_next = ihex_pkg::HEADER_CHARS + {1'b0, low_sum[7:0], 1'b0};
                take             = 1'b1;
                kind             = ihex_pkg::KIND_LENGTH;
                value            = low_sum;
            end
            10'd4: begin
                low_acc_next = {low_sum[7:0], 8'd0};
            end
            10'd5: begin
                low_acc_next = low_acc_reg + {8'd0, nib, 4'd0};
            end
            10'd6: begin
                low_acc_next = low_sum;
                take         = 1'b1;
                kind         = ihex_pkg::KIND_ADDRESS;
                value        = low_sum;
            end
            default: begin
            end
        endcase

        // data byte pairs, checksum falls past line_length
        if (pos > 10'd8 && pos < line_length_reg) begin
            case (pos[1:0])
                2'd1: begin
                    low_acc_next = {8'd0, nib, 4'd0};
                end
                2'd2: begin
                    low_acc_next = low_sum;
                end
                2'd3: begin
                    high_acc_next = {8'd0, nib, 4'd0};
                end
                default: begin
                    high_acc_next   = high_new;
                    low_acc_next    = low_acc_reg + high_new;
                    data_words_next = data_words_reg + 16'd1;
                    take            = 1'b1;
                    kind            = ihex_pkg::KIND_DATA;
                    value           = low_acc_reg + high_new;
                end
            endcase
        end

        char_position_next = (pos < ihex_pkg::POS_MAX) ? pos + 10'd1 : pos;

        ring_ptr_next = ring_ptr_reg;
        if (take) begin
            ring_ptr_next = (ring_ptr_reg == PTR_LAST) ? '0 : ring_ptr_reg + PTR_W'(1);
        end
    end

    always_comb begin
        slot_wide            = 32'(ring_ptr_reg);
        result.write_enable  = take;
        result.write_kind    = take ? kind : ihex_pkg::KIND_LENGTH;
        result.write_slot    = take ? slot_wide[5:0] : 6'd0;
        result.write_value   = take ? value : 16'd0;
        result.word_count    = data_words_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_position_reg <= ihex_pkg::POS_MAX;
            line_length_reg   <= 10'd0;
            low_acc_reg       <= 16'd0;
            high_acc_reg      <= 16'd0;
            ring_ptr_reg      <= '0;
            data_words_reg    <= 16'd0;
        end else if (step_en) begin
            char_position_reg <= char_position_next;
            line_length_reg   <= line_length_next;
            low_acc_reg       <= low_acc_next;
            high_acc_reg      <= high_acc_next;
            ring_ptr_reg      <= ring_ptr_next;
            data_words_reg    <= data_words_next;
        end
    end

endmodule

>>> hw/rtl/intel_hex_record_word_extractor.sv
// A character taken into the input register steps through the core into the result register.
// Throughput: one character per cycle unless m_tready stalls the output, set by the
// single-pass step logic between the input register and the result register.
// Reset: synchronous active-low aresetn empties both registers and sets the
// record state to idle until the first colon.
// ----------------------------------------------------------------------------
// intel_hex_record_word_extractor
// Input register, step core and result register for the hex record word
// extractor stream.
// ----------------------------------------------------------------------------
module intel_hex_record_word_extractor #(
    parameter int RING_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // in_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // write_enable, write_slot[6:1], write_value[22:7], word_count[38:23], zero pad
    output logic [ihex_pkg::TDATA_W-1:0] m_tdata,
    output logic [ihex_pkg::TUSER_W-1:0] m_tuser    // write_kind
);

    logic                   in_valid_reg;
    logic [7:0]             in_char_reg;
    logic                   out_valid_reg;
    ihex_pkg::ihex_result_t out_reg;
    ihex_pkg::ihex_result_t core_result;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ihex_core #(
        .RING_DEPTH(RING_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .in_char (in_char_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.word_count, out_reg.write_value,
                       out_reg.write_slot, out_reg.write_enable};
    assign m_tuser  = out_reg.write_kind;

endmodule
